@@ rtl/cqe_pkg.sv @@
// shared types and constants of the csv cell quoting encoder
`default_nettype none
package cqe_pkg;

	localparam logic [1:0] KIND_CHAR     = 2'd0;
	localparam logic [1:0] KIND_CELL_END = 2'd1;
	localparam logic [1:0] KIND_ROW_END  = 2'd2;

	localparam logic [7:0] DELIM_RESET = 8'd44;
	localparam logic [7:0] CH_DQUOTE   = 8'h22;
	localparam logic [7:0] CH_APOS     = 8'h27;
	localparam logic [7:0] CH_CR       = 8'h0d;
	localparam logic [7:0] CH_LF       = 8'h0a;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_SPACE    = 8'h20;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       overflow;
	} out_word_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_byte;
		logic       forces_quote;
	} token_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DELIM,
		ST_OPENQ,
		ST_CHAR,
		ST_DQ,
		ST_CLOSEQ,
		ST_CR,
		ST_LF
	} back_state_t;

endpackage
`default_nettype wire

@@ rtl/cqe_fifo.sv @@
// small first-in first-out queue of words
`default_nettype none
module cqe_fifo #(
	parameter type ITEM_T = logic [7:0],
	parameter int unsigned AW = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_en,
	input  wire ITEM_T wr_data,
	output logic       full,
	input  wire logic  rd_en,
	output ITEM_T      rd_data,
	output logic       empty
);
	localparam int unsigned DEPTH = 1 << AW;

	logic [AW:0] wr_ptr_q, rd_ptr_q;
	ITEM_T       mem_q [DEPTH];

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[AW] != rd_ptr_q[AW]) &&
	               (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
	assign rd_data = mem_q[rd_ptr_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en && !full)
				wr_ptr_q <= wr_ptr_q + (AW+1)'(1);
			if (rd_en && !empty)
				rd_ptr_q <= rd_ptr_q + (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !full)
			mem_q[wr_ptr_q[AW-1:0]] <= wr_data;
	end
endmodule
`default_nettype wire

@@ rtl/cqe_front.sv @@
// front end: accepts input words and tags characters that force quoting
`default_nettype none
module cqe_front (
	input  wire logic            push,
	output logic                 full,
	input  wire cqe_pkg::in_word_t in_word,
	input  wire logic [7:0]      delim,
	input  wire logic            tok_full,
	output logic                 tok_wr,
	output cqe_pkg::token_t      tok
);
	import cqe_pkg::*;

	logic fq;

	// quote decision uses the delimiter in force when the character arrives
	assign fq = (in_word.char_byte == CH_DQUOTE) || (in_word.char_byte == CH_APOS) ||
	            (in_word.char_byte == delim) || (in_word.char_byte == CH_CR) ||
	            (in_word.char_byte == CH_LF) || (in_word.char_byte == CH_TAB) ||
	            (in_word.char_byte == CH_SPACE);

	assign full = tok_full;

	always_comb begin
		tok.kind         = in_word.kind;
		tok.char_byte    = in_word.char_byte;
		tok.forces_quote = fq;
		unique case (in_word.kind)
			KIND_CHAR, KIND_CELL_END, KIND_ROW_END: tok_wr = push && !tok_full;
			// unused kind is taken and dropped here
			default: tok_wr = 1'b0;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/cqe_back.sv @@
// back end: cell buffer and byte sequencer that writes the csv text
`default_nettype none
module cqe_back #(
	parameter int unsigned MAX_CELL = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             tok_empty,
	input  wire cqe_pkg::token_t  tok,
	output logic                  tok_pop,
	input  wire logic [7:0]       delim,
	input  wire logic             out_full,
	output logic                  out_wr,
	output cqe_pkg::out_word_t    out_data
);
	import cqe_pkg::*;

	localparam int unsigned LW = $clog2(MAX_CELL + 1);
	localparam int unsigned IW = (MAX_CELL > 1) ? $clog2(MAX_CELL) : 1;

	back_state_t state_q, state_d;
	logic [7:0]    buf_q [MAX_CELL];
	logic [LW-1:0] len_q;
	logic [IW-1:0] idx_q;
	logic          quote_q, first_q, lost_q;

	logic [7:0] cur;
	logic       at_end, cur_dq, store, finish, adv;

	assign cur    = buf_q[idx_q];
	assign cur_dq = (cur == CH_DQUOTE);
	assign at_end = ((LW'(idx_q) + LW'(1)) == len_q);
	assign store  = (state_q == ST_IDLE) && !tok_empty && (tok.kind == KIND_CHAR) &&
	                (len_q < LW'(MAX_CELL));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!tok_empty) begin
					unique case (tok.kind)
						KIND_CELL_END: begin
							if (!first_q)
								state_d = ST_DELIM;
							else if (quote_q)
								state_d = ST_OPENQ;
							else if (len_q != '0)
								state_d = ST_CHAR;
						end
						KIND_ROW_END: state_d = ST_CR;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_DELIM: begin
				if (!out_full)
					state_d = quote_q ? ST_OPENQ : ((len_q != '0) ? ST_CHAR : ST_IDLE);
			end
			ST_OPENQ: begin
				if (!out_full)
					state_d = (len_q != '0) ? ST_CHAR : ST_CLOSEQ;
			end
			ST_CHAR: begin
				if (!out_full) begin
					if (cur_dq)
						state_d = ST_DQ;
					else if (at_end)
						state_d = quote_q ? ST_CLOSEQ : ST_IDLE;
				end
			end
			ST_DQ: begin
				if (!out_full)
					state_d = at_end ? (quote_q ? ST_CLOSEQ : ST_IDLE) : ST_CHAR;
			end
			ST_CLOSEQ: if (!out_full) state_d = ST_IDLE;
			ST_CR:     if (!out_full) state_d = ST_LF;
			ST_LF:     if (!out_full) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		tok_pop           = 1'b0;
		out_wr            = 1'b0;
		out_data.out_byte = '0;
		out_data.last     = 1'b0;
		out_data.overflow = lost_q;
		finish            = 1'b0;
		adv               = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				tok_pop = !tok_empty;
				// first empty unquoted cell of a row gives no bytes
				finish = !tok_empty && (tok.kind == KIND_CELL_END) && first_q &&
				         !quote_q && (len_q == '0);
			end
			ST_DELIM: begin
				out_wr            = !out_full;
				out_data.out_byte = delim;
				out_data.last     = !quote_q && (len_q == '0);
				finish            = !out_full && out_data.last;
			end
			ST_OPENQ: begin
				out_wr            = !out_full;
				out_data.out_byte = CH_DQUOTE;
			end
			ST_CHAR: begin
				out_wr            = !out_full;
				out_data.out_byte = cur;
				out_data.last     = !cur_dq && !quote_q && at_end;
				adv               = !out_full && !cur_dq;
				finish            = adv && at_end && !quote_q;
			end
			ST_DQ: begin
				out_wr            = !out_full;
				out_data.out_byte = CH_DQUOTE;
				out_data.last     = !quote_q && at_end;
				adv               = !out_full;
				finish            = adv && at_end && !quote_q;
			end
			ST_CLOSEQ: begin
				out_wr            = !out_full;
				out_data.out_byte = CH_DQUOTE;
				out_data.last     = 1'b1;
				finish            = !out_full;
			end
			ST_CR: begin
				out_wr            = !out_full;
				out_data.out_byte = CH_CR;
			end
			ST_LF: begin
				out_wr            = !out_full;
				out_data.out_byte = CH_LF;
				out_data.last     = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			idx_q   <= '0;
			quote_q <= 1'b0;
			first_q <= 1'b1;
			lost_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && !tok_empty && tok.kind == KIND_CHAR) begin
				if (store) begin
					len_q <= len_q + LW'(1);
					if (tok.forces_quote)
						quote_q <= 1'b1;
				end else begin
					lost_q <= 1'b1;
				end
			end
			if (adv)
				idx_q <= at_end ? '0 : idx_q + IW'(1);
			if (finish) begin
				len_q   <= '0;
				quote_q <= 1'b0;
				lost_q  <= 1'b0;
				first_q <= 1'b0;
			end
			if (state_q == ST_LF && !out_full)
				first_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (store)
			buf_q[len_q[IW-1:0]] <= tok.char_byte;
	end
endmodule
`default_nettype wire

@@ rtl/csv_cell_quoting_encoder.sv @@
// top level of the csv cell quoting encoder
//
// channel   direction  handshake            word
// in        input      push / full          in_word  (kind, char_byte)
// out       output     pop / empty          out_word (out_byte, last, overflow)
// cfg       input      cfg_wr_en            cfg_wr_data (delimiter byte)
//
// the back end sequencer takes characters while idle; for a cell end or row end it
// writes one byte per state (up to 2*MAX_CELL+3 per cell) while the output queue
// has room; four-word queues before and after it let input and output stall
// independently; reset clears all control state, the cell buffer needs no clearing
`default_nettype none
module csv_cell_quoting_encoder #(
	parameter int unsigned MAX_CELL = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire cqe_pkg::in_word_t  in_word,
	output logic                    empty,
	input  wire logic               pop,
	output cqe_pkg::out_word_t      out_word,
	input  wire logic               cfg_wr_en,
	input  wire logic [7:0]         cfg_wr_data
);
	import cqe_pkg::*;

	logic [7:0] delim_q;
	logic       tok_wr, tok_full, tok_empty, tok_pop;
	token_t     tok_in, tok_out;
	logic       out_wr, out_full;
	out_word_t  out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			delim_q <= DELIM_RESET;
		else if (cfg_wr_en)
			delim_q <= cfg_wr_data;
	end

	cqe_front u_front (
		.push     (push),
		.full     (full),
		.in_word  (in_word),
		.delim    (delim_q),
		.tok_full (tok_full),
		.tok_wr   (tok_wr),
		.tok      (tok_in)
	);

	cqe_fifo #(.ITEM_T(token_t), .AW(2)) u_tok_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tok_wr),
		.wr_data (tok_in),
		.full    (tok_full),
		.rd_en   (tok_pop),
		.rd_data (tok_out),
		.empty   (tok_empty)
	);

	cqe_back #(.MAX_CELL(MAX_CELL)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_empty (tok_empty),
		.tok       (tok_out),
		.tok_pop   (tok_pop),
		.delim     (delim_q),
		.out_full  (out_full),
		.out_wr    (out_wr),
		.out_data  (out_data)
	);

	cqe_fifo #(.ITEM_T(out_word_t), .AW(2)) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data (out_data),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (out_word),
		.empty   (empty)
	);
endmodule
`default_nettype wire

@@ sim/csv_encoding_checker.sv @@
// checker that predicts the encoder's csv text and compares every output word
module csv_encoding_checker #(
	parameter int unsigned MAX_CELL = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  cqe_pkg::in_word_t  in_word,
	input  logic               empty,
	input  logic               pop,
	input  cqe_pkg::out_word_t out_word,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data,
	output int                 errors,
	output int                 outstanding,
	output int                 words_in,
	output int                 bytes_out
);
	timeunit 1ns;
	timeprecision 1ps;
	import cqe_pkg::*;

	logic [7:0]  cell_chars [MAX_CELL];
	int unsigned cell_len;
	logic        quote_pend;
	logic        row_start;
	logic        chars_lost;
	logic [7:0]  delim;
	out_word_t   csv_bytes [$];
	out_word_t   want_word;
	int          err_count;
	int          n_in;
	int          n_out;

	function automatic logic needs_quotes(input logic [7:0] c);
		return c == CH_DQUOTE || c == CH_APOS || c == delim || c == CH_CR ||
			c == CH_LF || c == CH_TAB || c == CH_SPACE;
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic encode_item(input in_word_t w);
		logic [7:0] text [$];
		logic       ovf;
		ovf = chars_lost;
		case (w.kind)
			KIND_CHAR: begin
				if (cell_len < MAX_CELL) begin
					cell_chars[cell_len] = w.char_byte;
					cell_len++;
					// quoting is decided on arrival, against the delimiter of that moment
					if (needs_quotes(w.char_byte))
						quote_pend = 1'b1;
				end else begin
					chars_lost = 1'b1;
				end
			end
			KIND_CELL_END: begin
				if (!row_start)
					text.push_back(delim);
				if (quote_pend)
					text.push_back(CH_DQUOTE);
				for (int i = 0; i < cell_len; i++) begin
					if (cell_chars[i] == CH_DQUOTE)
						text.push_back(CH_DQUOTE);
					text.push_back(cell_chars[i]);
				end
				if (quote_pend)
					text.push_back(CH_DQUOTE);
				cell_len = 0;
				quote_pend = 1'b0;
				chars_lost = 1'b0;
				row_start = 1'b0;
			end
			KIND_ROW_END: begin
				// an unclosed cell stays buffered and joins the next row
				text.push_back(CH_CR);
				text.push_back(CH_LF);
				row_start = 1'b1;
			end
			default: begin
			end
		endcase
		foreach (text[i])
			csv_bytes.push_back('{out_byte: text[i], last: (i == text.size() - 1),
				overflow: ovf});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_len = 0;
			quote_pend = 1'b0;
			row_start = 1'b1;
			chars_lost = 1'b0;
			delim = DELIM_RESET;
			csv_bytes.delete();
			err_count = 0;
			n_in = 0;
			n_out = 0;
			errors <= 0;
			outstanding <= 0;
			words_in <= 0;
			bytes_out <= 0;
		end else begin
			if (cfg_wr_en)
				delim = cfg_wr_data;
			if (push && !full) begin
				encode_item(in_word);
				n_in++;
			end
			if (pop && !empty) begin
				n_out++;
				if (csv_bytes.size() == 0) begin
					report_error($sformatf("byte %0d (%02h) arrived with nothing expected",
						n_out, out_word.out_byte));
				end else begin
					want_word = csv_bytes.pop_front();
					if (out_word !== want_word)
						report_error($sformatf(
							"byte %0d: got %02h last %b ovf %b, want %02h last %b ovf %b",
							n_out, out_word.out_byte, out_word.last, out_word.overflow,
							want_word.out_byte, want_word.last, want_word.overflow));
				end
			end
			outstanding <= csv_bytes.size();
			errors <= err_count;
			words_in <= n_in;
			bytes_out <= n_out;
		end
	end

endmodule

@@ sim/csv_cell_quoting_encoder_tb.sv @@
// top of the csv cell quoting encoder testbench: clock, reset, stimulus and verdict
module csv_cell_quoting_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cqe_pkg::*;

	localparam int unsigned MAX_CELL      = 16;
	localparam logic [1:0]  KIND_UNUSED   = 2'd3;
	localparam int          CYCLE_LIMIT   = 500_000;
	localparam int          SETTLE_CYCLES = 16;
	localparam int          TAIL_CYCLES   = 40;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          PHASE_WORDS   = 52;
	localparam int          N_PHASES      = 7;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	in_word_t   in_word = '0;
	logic       empty;
	logic       pop = 1'b0;
	out_word_t  out_word;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = '0;

	int         errors;
	int         outstanding;
	int         words_in;
	int         bytes_out;
	int         cycle_count = 0;
	int         sent_words = 0;
	logic [7:0] delim_now = DELIM_RESET;
	bit         send_burst = 1'b0;
	bit         recv_burst = 1'b0;
	bit         hold_request = 1'b0;

	csv_cell_quoting_encoder #(.MAX_CELL(MAX_CELL)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_word     (in_word),
		.empty       (empty),
		.pop         (pop),
		.out_word    (out_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	csv_encoding_checker #(.MAX_CELL(MAX_CELL)) enc_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_word     (in_word),
		.empty       (empty),
		.pop         (pop),
		.out_word    (out_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.errors      (errors),
		.outstanding (outstanding),
		.words_in    (words_in),
		.bytes_out   (bytes_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("run stopped: no progress within %0d cycles", CYCLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [7:0] pick_char();
		logic [7:0] specials [8];
		specials = '{CH_DQUOTE, CH_APOS, CH_CR, CH_LF, CH_TAB, CH_SPACE, delim_now, 8'h2c};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 8'($urandom_range(8'h61, 8'h7a));
			5, 6, 7: return specials[$urandom_range(0, 7)];
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic offer_word(input logic [1:0] kind, input logic [7:0] ch);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_word <= '{kind: kind, char_byte: ch};
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (kind != KIND_UNUSED)
			sent_words++;
	endtask

	// wait until every predicted byte is out, then let buffered characters settle
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_delimiter(input logic [7:0] value);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		delim_now = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_row();
		int cells;
		int len;
		send_burst = ($urandom_range(0, 3) == 0);
		cells = $urandom_range(0, 5);
		repeat (cells) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_CELL - 2, MAX_CELL + 3)
				: $urandom_range(0, 6);
			repeat (len)
				offer_word(KIND_CHAR, pick_char());
			if ($urandom_range(0, 19) == 0)
				offer_word(KIND_UNUSED, 8'($urandom));
			offer_word(KIND_CELL_END, 8'($urandom));
		end
		// now and then a row ends on an unclosed cell
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3))
				offer_word(KIND_CHAR, pick_char());
		offer_word(KIND_ROW_END, 8'($urandom));
	endtask

	initial begin : result_sink
		int gap;
		int hold_count;
		int pops;
		pops = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				pop <= 1'b0;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(posedge clk);
					hold_count++;
				end
				hold_request = 1'b0;
			end
			pops++;
			if (pops % 40 == 0)
				recv_burst = ($urandom_range(0, 2) == 0);
			gap = recv_burst ? 0 : $urandom_range(0, 4);
			repeat (gap) begin
				pop <= 1'b0;
				@(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
		end
	end

	initial begin : stimulus
		logic [7:0] delim_plan [N_PHASES - 1];
		int         target;
		int         mid;
		bit         paused;
		delim_plan = '{8'h00, 8'hff, CH_TAB, CH_DQUOTE, 8'($urandom_range(0, 255)),
			DELIM_RESET};
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_word(KIND_CELL_END, 8'h00);
		offer_word(KIND_CHAR, 8'h00);
		offer_word(KIND_CHAR, 8'hff);
		offer_word(KIND_CELL_END, 8'hff);
		offer_word(KIND_CELL_END, 8'h5a);
		offer_word(KIND_CHAR, CH_DQUOTE);
		offer_word(KIND_CELL_END, 8'h00);
		offer_word(KIND_UNUSED, 8'haa);
		offer_word(KIND_ROW_END, 8'h00);
		// one character too many, with the cell still open across a row end
		repeat (MAX_CELL + 1)
			offer_word(KIND_CHAR, 8'($urandom_range(8'h61, 8'h7a)));
		offer_word(KIND_ROW_END, 8'h00);
		offer_word(KIND_CELL_END, 8'h00);
		offer_word(KIND_ROW_END, 8'h00);
		drain_results();

		for (int phase = 0; phase < N_PHASES; phase++) begin
			if (phase > 0)
				write_delimiter(delim_plan[phase - 1]);
			target = sent_words + PHASE_WORDS;
			mid = sent_words + PHASE_WORDS / 2;
			paused = 1'b0;
			// long receiver stall while words keep coming, so the input backs up
			if (phase == 1)
				hold_request = 1'b1;
			while (sent_words < target) begin
				send_row();
				if (phase == 2 && !paused && sent_words >= mid) begin
					drain_results();
					paused = 1'b1;
				end
			end
		end

		drain_results();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		$display("run covered %0d input words and %0d output bytes over %0d delimiter values",
			words_in, bytes_out, N_PHASES);
		$display("with empty, quoted, overfull and row-spanning cells plus ignored words");
		if (errors == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
